FILE: hw/rtl/binary_trie_max_xor_macros.svh
// assertion helpers used by binary_trie_max_xor.sv
`ifndef BINARY_TRIE_MAX_XOR_MACROS_SVH
`define BINARY_TRIE_MAX_XOR_MACROS_SVH

// condition holds at every clock edge out of reset
`define BTMX_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BTMX_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define BTMX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/btmx_pkg.sv
package btmx_pkg;

    // request kinds on the input tuser bit
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_ANSWERED = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    // walk sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_QUERY,
        ST_CLOSE,
        ST_DONE
    } state_t;

endpackage

FILE: hw/rtl/btmx_ram.sv
module btmx_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/binary_trie_max_xor.sv
// binary trie holding unsigned keys, answering maximum-xor queries
// input channel s_axis: one item per request; tuser[0] is the kind (0 insert,
// 1 query), tdata[31:0] is the key. output channel m_axis: exactly one item
// per request; tuser[1:0] is the status (0 inserted, 1 insert dropped because
// the node store is full, 2 query answered, 3 query on an empty trie),
// tdata[31:0] the largest xor for an answered query and zero otherwise.
//
// every insert or query walks the trie one level per cycle through the node
// memory, KEY_BITS levels from the top key bit down, and an insert that adds
// nodes then clears its new leaf; full and empty cases skip the walk. a
// result passes from the walker's done state into the output register, and
// the walker takes no next item until its result has moved there.
// s_axis_tready is high only while the walker is free.
//
// reset clears the root's children, the free-node pointer (to one) and the
// not-empty flag; no clearing pass runs, since a node is always written when
// it is allocated. a result waiting on a stalled m_axis stays in the output
// register while the next item is accepted and walked; that item's result
// then waits in the walker until the output register frees up.
`include "binary_trie_max_xor_macros.svh"

module binary_trie_max_xor #(
    parameter int KEY_BITS   = 32,
    parameter int NODE_COUNT = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // key[31:0]
    input  logic [0:0]  s_axis_tuser,   // req_type[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // max_xor[31:0]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    import btmx_pkg::*;

    localparam int NODE_W = $clog2(NODE_COUNT);   // child index width
    localparam int CNT_W  = NODE_W + 1;           // free pointer can reach NODE_COUNT
    localparam int LVL_W  = $clog2(KEY_BITS);

    // walk state
    state_t              state_reg, state_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] acc_reg, acc_next;
    logic [LVL_W-1:0]    level_reg, level_next;
    logic [NODE_W-1:0]   cur_reg, cur_next;
    logic                alloc_reg, alloc_next;
    status_t             status_reg, status_next;

    // trie bookkeeping; node 0 (root) lives in flops so reset can clear it
    logic [NODE_W-1:0]   root0_reg, root0_next;
    logic [NODE_W-1:0]   root1_reg, root1_next;
    logic [CNT_W-1:0]    next_free_reg, next_free_next;
    logic                not_empty_reg, not_empty_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [31:0]         out_data_reg, out_data_next;

    // node memory port
    logic                  ram_we;
    logic [NODE_W-1:0]     ram_waddr;
    logic [2*NODE_W-1:0]   ram_wdata;
    logic                  ram_re;
    logic [NODE_W-1:0]     ram_raddr;
    logic [2*NODE_W-1:0]   ram_rdata;

    // helpers
    logic [KEY_BITS-1:0] key_ext;
    logic [31:0]         acc32;
    logic                key_bit;
    logic                last_level;
    logic [NODE_W-1:0]   child0;
    logic [NODE_W-1:0]   child1;
    logic [NODE_W-1:0]   new_idx;
    logic                store_full;

    btmx_ram #(
        .WIDTH(2 * NODE_W),
        .DEPTH(NODE_COUNT)
    ) u_node_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // fit the 32-bit key to the trie depth, and the answer back to 32 bits
    generate
        if (KEY_BITS > 32)
        begin : g_wide_key
            assign key_ext = {{(KEY_BITS - 32){1'b0}}, s_axis_tdata};
            assign acc32   = acc_reg[31:0];
        end
        else if (KEY_BITS == 32)
        begin : g_exact_key
            assign key_ext = s_axis_tdata;
            assign acc32   = acc_reg;
        end
        else
        begin : g_narrow_key
            assign key_ext = s_axis_tdata[KEY_BITS-1:0];
            assign acc32   = {{(32 - KEY_BITS){1'b0}}, acc_reg};
        end
    endgenerate

    assign key_bit    = key_reg[level_reg];
    assign last_level = (level_reg == '0);
    assign new_idx    = next_free_reg[NODE_W-1:0];

    // children of the current node: root from flops, others from the read
    // issued in the previous cycle
    assign child0 = (cur_reg == '0) ? root0_reg : ram_rdata[NODE_W-1:0];
    assign child1 = (cur_reg == '0) ? root1_reg : ram_rdata[2*NODE_W-1:NODE_W];

    // conservative room check: a full-depth path must fit
    assign store_full = ({1'b0, next_free_reg} + (CNT_W + 1)'(KEY_BITS))
                        > (CNT_W + 1)'(NODE_COUNT);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alloc_reg     <= 1'b0;
            root0_reg     <= '0;
            root1_reg     <= '0;
            next_free_reg <= CNT_W'(1);
            not_empty_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alloc_reg     <= alloc_next;
            root0_reg     <= root0_next;
            root1_reg     <= root1_next;
            next_free_reg <= next_free_next;
            not_empty_reg <= not_empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        acc_reg        <= acc_next;
        level_reg      <= level_next;
        cur_reg        <= cur_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        acc_next        = acc_reg;
        level_next      = level_reg;
        cur_next        = cur_reg;
        alloc_next      = alloc_reg;
        status_next     = status_reg;
        root0_next      = root0_reg;
        root1_next      = root1_reg;
        next_free_next  = next_free_reg;
        not_empty_next  = not_empty_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = cur_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = cur_reg;

        // the output register empties when the item is taken
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    key_next   = key_ext;
                    acc_next   = '0;
                    level_next = LVL_W'(KEY_BITS - 1);
                    cur_next   = '0;
                    alloc_next = 1'b0;
                    if (s_axis_tuser[0] == REQ_INSERT)
                    begin
                        if (store_full)
                        begin
                            status_next = STAT_FULL;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_INSERT;
                        end
                    end
                    else if (!not_empty_reg)
                    begin
                        status_next = STAT_EMPTY;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_QUERY;
                    end
                end
            end

            ST_INSERT:
            begin
                if (alloc_reg)
                begin
                    // current node is fresh: write it once with its only child
                    ram_we         = 1'b1;
                    ram_waddr      = cur_reg;
                    ram_wdata      = key_bit ? {new_idx, {NODE_W{1'b0}}}
                                             : {{NODE_W{1'b0}}, new_idx};
                    next_free_next = next_free_reg + CNT_W'(1);
                    cur_next       = new_idx;
                end
                else if ((key_bit ? child1 : child0) != '0)
                begin
                    // path exists, follow it
                    cur_next  = key_bit ? child1 : child0;
                    ram_re    = 1'b1;
                    ram_raddr = key_bit ? child1 : child0;
                end
                else
                begin
                    // path ends here: hang a new node off the current one
                    if (cur_reg == '0)
                    begin
                        if (key_bit)
                        begin
                            root1_next = new_idx;
                        end
                        else
                        begin
                            root0_next = new_idx;
                        end
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_reg;
                        ram_wdata = key_bit ? {new_idx, child0} : {child1, new_idx};
                    end
                    next_free_next = next_free_reg + CNT_W'(1);
                    cur_next       = new_idx;
                    alloc_next     = 1'b1;
                end

                if (last_level)
                begin
                    if (alloc_next)
                    begin
                        state_next = ST_CLOSE;
                    end
                    else
                    begin
                        // duplicate key, nothing added
                        status_next    = STAT_INSERTED;
                        not_empty_next = 1'b1;
                        state_next     = ST_DONE;
                    end
                end
                else
                begin
                    level_next = level_reg - LVL_W'(1);
                end
            end

            ST_CLOSE:
            begin
                // new leaf gets null children
                ram_we         = 1'b1;
                ram_waddr      = cur_reg;
                ram_wdata      = '0;
                status_next    = STAT_INSERTED;
                not_empty_next = 1'b1;
                state_next     = ST_DONE;
            end

            ST_QUERY:
            begin
                if ((key_bit ? child0 : child1) != '0)
                begin
                    // opposite bit available, answer bit set
                    acc_next[level_reg] = 1'b1;
                    cur_next            = key_bit ? child0 : child1;
                end
                else
                begin
                    cur_next = key_bit ? child1 : child0;
                end

                if (last_level || (cur_next == '0))
                begin
                    status_next = STAT_ANSWERED;
                    state_next  = ST_DONE;
                end
                else
                begin
                    level_next = level_reg - LVL_W'(1);
                    ram_re     = 1'b1;
                    ram_raddr  = cur_next;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_data_next   = (status_reg == STAT_ANSWERED) ? acc32 : '0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // allocation stays inside the node store
    `BTMX_ASSERT_ALWAYS(a_free_in_range, next_free_reg <= CNT_W'(NODE_COUNT),
        "free node pointer beyond node store")
    // once a path is being extended every level writes one node
    `BTMX_ASSERT_IMPL(a_alloc_writes, (state_reg == ST_INSERT) && alloc_reg, ram_we,
        "allocating insert level without node write")
    // only an answered query carries a nonzero value
    `BTMX_ASSERT_IMPL(a_zero_unless_answer,
        m_axis_tvalid && (m_axis_tuser != STAT_ANSWERED), m_axis_tdata == '0,
        "nonzero data on a result that is not an answer")
    // keys are never removed
    `BTMX_ASSERT_NEXT(a_stays_not_empty, not_empty_reg, not_empty_reg,
        "trie became empty after an insert")

endmodule
